@@ rtl/core/oaid_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the ordered array store.
// Used by oaid_cell and by ordered_array_insert_delete; depends on nothing.
package oaid_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int FIELD_W       = 7;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
    localparam logic [1:0] STAT_BAD_POS  = 2'd2;
    localparam logic [1:0] STAT_PAST_END = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD     = 2'd0,
        CELL_INSERT   = 2'd1,
        CELL_SHIFT_DN = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

@@ rtl/core/oaid_cell.sv @@
`timescale 1ns / 1ps
// One entry of the ordered array: holds a word and moves it to or from its neighbors.
// Depends on oaid_pkg.
module oaid_cell #(
    parameter int POS_W = 8
) (
    input  logic                           clk,
    input  oaid_pkg::cell_cmd_t            cmd,
    input  logic [POS_W-1:0]               idx,
    input  logic [POS_W-1:0]               pos,
    input  logic [oaid_pkg::WORD_W-1:0]    lower,
    input  logic [oaid_pkg::WORD_W-1:0]    upper,
    output logic [oaid_pkg::WORD_W-1:0]    word,
    output logic [oaid_pkg::WORD_W-1:0]    rd_tap
);
    import oaid_pkg::*;

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (idx == pos)
                begin
                    entry_next = cmd.word;
                end
                else if (idx > pos)
                begin
                    entry_next = lower;
                end
            end
            CELL_SHIFT_DN:
            begin
                if (idx >= pos)
                begin
                    entry_next = upper;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign word   = entry_reg;
    assign rd_tap = (idx == pos) ? entry_reg : '0;

endmodule

@@ rtl/core/ordered_array_insert_delete.sv @@
`timescale 1ns / 1ps
// Ordered array store: append, insert, delete run and read over a row of entry cells.
// Depends on oaid_pkg and oaid_cell.
// Latency: the result beat is presented the cycle after the request beat is taken.
// Throughput: append, insert, read, rejected requests and deletes of zero entries finish when
// taken; a delete of n entries does one single-place shift down per cycle, n shifts in all.
// Reset clears the live count and the output valid flag; entry contents are not cleared.
module ordered_array_insert_delete #(
    parameter int DEPTH = oaid_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // position[6:0], value[38:7], amount[45:39], zero pad
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // read_value[31:0], element_count[38:32], status[40:39]
);
    import oaid_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SHIFT = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [FIELD_W-1:0]   rem_reg, rem_next;
    logic [CMP_W-1:0]     pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [47:0]          out_data_reg, out_data_next;

    logic                 accept;
    logic [1:0]           req;
    logic [FIELD_W-1:0]   pos_in;
    logic [WORD_W-1:0]    val_in;
    logic [FIELD_W-1:0]   amt_in;
    logic [CMP_W-1:0]     pos_x, amt_x, cnt_x, need_x, free_x, sum_x, new_cnt_x;
    logic [1:0]           status;
    logic [WORD_W-1:0]    rd_value;
    logic [WORD_W-1:0]    rd_or;
    cell_cmd_t            cmd;
    logic [CMP_W-1:0]     cell_pos;

    logic [WORD_W-1:0]    words [DEPTH];
    logic [WORD_W-1:0]    taps  [DEPTH];

    assign req    = s_tuser;
    assign pos_in = s_tdata[6:0];
    assign val_in = s_tdata[38:7];
    assign amt_in = s_tdata[45:39];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign pos_x  = {{(CMP_W-FIELD_W){1'b0}}, pos_in};
    assign amt_x  = {{(CMP_W-FIELD_W){1'b0}}, amt_in};
    assign cnt_x  = {{(CMP_W-CNT_W){1'b0}}, count_reg};
    assign need_x = (amt_in == '0) ? CMP_W'(1) : amt_x;
    assign free_x = DEPTH_C - cnt_x;
    assign sum_x  = pos_x + amt_x;

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | taps[i];
        end
    end

    always_comb
    begin
        status    = STAT_OK;
        rd_value  = '0;
        new_cnt_x = cnt_x;
        cmd.op    = CELL_HOLD;
        cmd.word  = val_in;
        cell_pos  = pos_x;
        case (req)
            REQ_APPEND:
            begin
                cell_pos = cnt_x;
                if (cnt_x >= DEPTH_C)
                begin
                    status = STAT_NO_ROOM;
                end
                else
                begin
                    cmd.op    = CELL_INSERT;
                    new_cnt_x = cnt_x + CMP_W'(1);
                end
            end
            REQ_INSERT:
            begin
                if ((cnt_x >= DEPTH_C) || (need_x > free_x))
                begin
                    status = STAT_NO_ROOM;
                end
                else if (pos_x > cnt_x)
                begin
                    status = STAT_BAD_POS;
                end
                else
                begin
                    cmd.op    = CELL_INSERT;
                    new_cnt_x = cnt_x + CMP_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (pos_x > cnt_x)
                begin
                    status = STAT_BAD_POS;
                end
                else if (sum_x > cnt_x)
                begin
                    status = STAT_PAST_END;
                end
                else if (amt_in != '0)
                begin
                    cmd.op    = CELL_SHIFT_DN;
                    new_cnt_x = cnt_x - amt_x;
                end
            end
            REQ_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    status = STAT_BAD_POS;
                end
                else
                begin
                    rd_value = rd_or;
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase
        if (!accept)
        begin
            cmd.op = CELL_HOLD;
        end
        if (state_reg == ST_SHIFT)
        begin
            cmd.op   = CELL_SHIFT_DN;
            cell_pos = pos_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next     = new_cnt_x[CNT_W-1:0];
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, status, new_cnt_x[FIELD_W-1:0], rd_value};
                    pos_next       = pos_x;
                    rem_next       = amt_in - FIELD_W'(1);
                    if ((cmd.op == CELL_SHIFT_DN) && (amt_in > FIELD_W'(1)))
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                rem_next = rem_reg - FIELD_W'(1);
                if (rem_reg == FIELD_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_W-1:0] lower_w;
        logic [WORD_W-1:0] upper_w;
        if (g == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = words[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = words[g+1];
        end
        oaid_cell #(
            .POS_W (CMP_W)
        ) u_cell (
            .clk    (clk),
            .cmd    (cmd),
            .idx    (CMP_W'(g)),
            .pos    (cell_pos),
            .lower  (lower_w),
            .upper  (upper_w),
            .word   (words[g]),
            .rd_tap (taps[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
